FILE: src/arlt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arlt_pkg
// Shared types and constants for the address range label table.
// ----------------------------------------------------------------------------
package arlt_pkg;

	localparam int ENTRIES    = 16;
	localparam int NAME_BYTES = 8;
	localparam int MAX_OUT    = 16;

	localparam int KEY_W   = 64;
	localparam int ADDR_W  = 32;
	localparam int KIND_W  = 4;
	localparam int MODE_W  = 3;
	localparam int STAT_W  = 2;
	localparam int MAXM_W  = 5;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int FOUND_W = $clog2(MAX_OUT + 1);

	localparam logic [KEY_W-1:0] KEY_MASK = (NAME_BYTES >= 8) ? {KEY_W{1'b1}} :
		((KEY_W'(1) << (8 * NAME_BYTES)) - KEY_W'(1));

	localparam logic [MODE_W-1:0] M_ADD     = 3'd0;
	localparam logic [MODE_W-1:0] M_REMOVE  = 3'd1;
	localparam logic [MODE_W-1:0] M_FIND    = 3'd2;
	localparam logic [MODE_W-1:0] M_LOOKUP  = 3'd3;
	localparam logic [MODE_W-1:0] M_OVERLAP = 3'd4;
	localparam logic [MODE_W-1:0] M_PIN     = 3'd5;
	localparam logic [MODE_W-1:0] M_UNPIN   = 3'd6;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd1;
	localparam logic [STAT_W-1:0] ST_REJECT   = 2'd2;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] size;
		logic [KIND_W-1:0] kind;
		logic              pin;
	} entry_t;

	typedef struct packed {
		logic key_hit;
		logic addr_hit;
		logic ovl_hit;
	} match_t;

endpackage
`default_nettype wire

FILE: src/arlt_match.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arlt_match
// Compare unit shared by every scan step: key, address and overlap tests of
// one stored entry against the current query.
// ----------------------------------------------------------------------------
module arlt_match import arlt_pkg::*; (
	input  entry_t            entry,
	input  logic [KEY_W-1:0]  key,
	input  logic [ADDR_W-1:0] address,
	input  logic [ADDR_W-1:0] qend,
	output match_t            hit
);

	logic [ADDR_W-1:0] ent_end;

	assign ent_end = entry.start + entry.size;

	// an entry whose end wraps to or below its start never hits an address
	assign hit.key_hit  = (entry.key == key);
	assign hit.addr_hit = (address >= entry.start) && (address < ent_end);
	assign hit.ovl_hit  = (entry.start < qend) && (ent_end > address);

endmodule
`default_nettype wire

FILE: src/address_range_label_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// address_range_label_table
// Table of labeled address regions with add, remove, find, lookup, overlap,
// pin and unpin transactions.
// ----------------------------------------------------------------------------
// One transaction at a time. Each transaction reads every stored entry once
// through a single compare unit, one entry per cycle from the entry memory
// while the scan is not paused, then settles and commits. An overlap query
// returns up to max_matches results (at most MAX_OUT) in table order, or a
// single not-found result if none match; the final one has last set. All but
// its final result leave while the scan runs, and a stall on the result side
// pauses the scan. Every other transaction returns exactly one result.
// ----------------------------------------------------------------------------
module address_range_label_table import arlt_pkg::*; (
	input  wire               clk,
	input  wire               arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [MODE_W-1:0] mode,
	input  logic [KEY_W-1:0]  name_key,
	input  logic [ADDR_W-1:0] address,
	input  logic [ADDR_W-1:0] length,
	input  logic [KIND_W-1:0] kind,
	input  logic [MAXM_W-1:0] max_matches,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [STAT_W-1:0] status,
	output logic [ADDR_W-1:0] start_address,
	output logic [ADDR_W-1:0] region_size,
	output logic [KIND_W-1:0] entry_kind,
	output logic              is_pinned,
	output logic              last
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t state_q;

	logic [MODE_W-1:0]  mode_q;
	logic [KEY_W-1:0]   key_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [ADDR_W-1:0]  len_q;
	logic [ADDR_W-1:0]  qend_q;
	logic [KIND_W-1:0]  kind_q;
	logic [FOUND_W-1:0] maxm_q;

	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   scan_idx_q;
	logic               rd_vld_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	entry_t             rdata_s1;
	entry_t             mem [ENTRIES];

	logic               first_vld_q;
	logic [IDX_W-1:0]   first_idx_q;
	entry_t             first_ent_q;
	entry_t             last_ent_q;
	logic               pend_vld_q;
	entry_t             pend_q;
	logic [FOUND_W-1:0] found_q;

	logic               out_vld_q;
	logic [STAT_W-1:0]  out_stat_q;
	entry_t             out_ent_q;
	logic               out_last_q;

	match_t             hit;
	logic               scan_busy;
	logic               issue;
	logic               chk;
	logic               first_cand;
	logic               ovl_cand;
	logic               out_free;
	logic               advance;
	logic               push_mid;
	logic               scan_done;
	logic               done_fire;
	logic [CNT_W-1:0]   last_idx;

	logic [STAT_W-1:0]  res_stat;
	entry_t             res_ent;
	logic               res_has;
	logic               we;
	logic [IDX_W-1:0]   wr_idx;
	entry_t             wr_ent;
	logic               cnt_inc;
	logic               cnt_dec;
	entry_t             new_ent;
	entry_t             pin_ent;
	logic [MAXM_W-1:0]  maxm_sat;

	arlt_match u_match (
		.entry   (rdata_s1),
		.key     (key_q),
		.address (addr_q),
		.qend    (qend_q),
		.hit     (hit)
	);

	assign in_stall  = (state_q != S_IDLE);
	assign scan_busy = (state_q == S_SCAN);
	assign out_free  = !out_vld_q || !out_stall;
	assign chk       = scan_busy && rd_vld_s1;
	assign first_cand = chk && ((mode_q == M_LOOKUP) ? hit.addr_hit : hit.key_hit);
	assign ovl_cand  = chk && (mode_q == M_OVERLAP) && hit.ovl_hit && (found_q < maxm_q);
	assign advance   = !(ovl_cand && pend_vld_q && !out_free);
	assign push_mid  = ovl_cand && pend_vld_q && out_free;
	assign issue     = scan_busy && advance && (scan_idx_q != count_q);
	assign scan_done = scan_busy && (scan_idx_q == count_q) && !rd_vld_s1;
	assign done_fire = (state_q == S_DONE) && out_free;
	assign last_idx  = count_q - CNT_W'(1);
	assign maxm_sat  = (max_matches > MAXM_W'(MAX_OUT)) ? MAXM_W'(MAX_OUT) : max_matches;

	always_comb begin
		new_ent       = '0;
		new_ent.key   = key_q;
		new_ent.start = addr_q;
		new_ent.size  = len_q;
		new_ent.kind  = kind_q;
		pin_ent       = first_ent_q;
		pin_ent.pin   = (mode_q == M_PIN);
	end

	always_comb begin
		res_stat = ST_REJECT;
		res_has  = 1'b0;
		res_ent  = first_ent_q;
		we       = 1'b0;
		wr_idx   = first_idx_q;
		wr_ent   = pin_ent;
		cnt_inc  = 1'b0;
		cnt_dec  = 1'b0;
		unique case (mode_q)
			M_ADD: begin
				if (count_q == CNT_W'(ENTRIES)) begin
					res_stat = ST_REJECT;
				end else if (first_vld_q) begin
					res_stat = ST_REJECT;
					res_has  = 1'b1;
				end else begin
					res_stat = ST_OK;
					res_has  = 1'b1;
					res_ent  = new_ent;
					we       = 1'b1;
					wr_idx   = count_q[IDX_W-1:0];
					wr_ent   = new_ent;
					cnt_inc  = 1'b1;
				end
			end
			M_REMOVE: begin
				if (!first_vld_q) begin
					res_stat = ST_NOTFOUND;
				end else if (first_ent_q.pin) begin
					res_stat = ST_REJECT;
					res_has  = 1'b1;
				end else begin
					res_stat = ST_OK;
					res_has  = 1'b1;
					we       = 1'b1;
					wr_ent   = last_ent_q;
					cnt_dec  = 1'b1;
				end
			end
			M_FIND, M_LOOKUP: begin
				res_stat = first_vld_q ? ST_OK : ST_NOTFOUND;
				res_has  = first_vld_q;
			end
			M_OVERLAP: begin
				res_stat = pend_vld_q ? ST_OK : ST_NOTFOUND;
				res_has  = pend_vld_q;
				res_ent  = pend_q;
			end
			M_PIN, M_UNPIN: begin
				res_stat = first_vld_q ? ST_OK : ST_NOTFOUND;
				res_has  = first_vld_q;
				res_ent  = pin_ent;
				we       = first_vld_q;
			end
			default: begin
				res_stat = ST_REJECT;
			end
		endcase
		if (!res_has) begin
			res_ent = '0;
		end
	end

	// entry memory
	always_ff @(posedge clk) begin
		if (issue) begin
			rdata_s1 <= mem[scan_idx_q[IDX_W-1:0]];
		end
		if (done_fire && we) begin
			mem[wr_idx] <= wr_ent;
		end
	end

	// query and scan payload
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mode_q <= mode;
			key_q  <= name_key & KEY_MASK;
			addr_q <= address;
			len_q  <= length;
			qend_q <= address + length;
			kind_q <= kind;
			maxm_q <= FOUND_W'(maxm_sat);
		end
		if (scan_busy && advance) begin
			rd_idx_s1 <= scan_idx_q[IDX_W-1:0];
			if (first_cand && !first_vld_q) begin
				first_idx_q <= rd_idx_s1;
				first_ent_q <= rdata_s1;
			end
			if (chk && (CNT_W'(rd_idx_s1) == last_idx)) begin
				last_ent_q <= rdata_s1;
			end
			if (ovl_cand) begin
				pend_q <= rdata_s1;
			end
		end
		if (push_mid) begin
			out_stat_q <= ST_OK;
			out_ent_q  <= pend_q;
			out_last_q <= 1'b0;
		end else if (done_fire) begin
			out_stat_q <= res_stat;
			out_ent_q  <= res_ent;
			out_last_q <= 1'b1;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			scan_idx_q  <= '0;
			rd_vld_s1   <= 1'b0;
			first_vld_q <= 1'b0;
			pend_vld_q  <= 1'b0;
			found_q     <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q     <= S_SCAN;
						scan_idx_q  <= '0;
						rd_vld_s1   <= 1'b0;
						first_vld_q <= 1'b0;
						pend_vld_q  <= 1'b0;
						found_q     <= '0;
					end
				end
				S_SCAN: begin
					if (scan_done) begin
						state_q <= S_DONE;
					end else if (advance) begin
						rd_vld_s1 <= issue;
						if (issue) begin
							scan_idx_q <= scan_idx_q + CNT_W'(1);
						end
						if (first_cand) begin
							first_vld_q <= 1'b1;
						end
						if (ovl_cand) begin
							pend_vld_q <= 1'b1;
							found_q    <= found_q + FOUND_W'(1);
						end
					end
				end
				S_DONE: begin
					if (done_fire) begin
						state_q <= S_IDLE;
						if (cnt_inc) begin
							count_q <= count_q + CNT_W'(1);
						end else if (cnt_dec) begin
							count_q <= count_q - CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (push_mid || done_fire) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_vld_q;
	assign status        = out_stat_q;
	assign start_address = out_ent_q.start;
	assign region_size   = out_ent_q.size;
	assign entry_kind    = out_ent_q.kind;
	assign is_pinned     = out_ent_q.pin;
	assign last          = out_last_q;

endmodule
`default_nettype wire
